// ===== hw/rtl/map_line_rasterizer_assert.svh =====
// Assertion macros shared by the map line rasterizer RTL.
`ifndef MAP_LINE_RASTERIZER_ASSERT_SVH
`define MAP_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MLR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("map_line_rasterizer: assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("map_line_rasterizer: assertion failed");

`endif

// ===== hw/rtl/mlr_pkg.sv =====
// Shared widths, constants and multiply-divide request types for the map line rasterizer.
`default_nettype none

package mlr_pkg;

  localparam int OP_W   = 1;
  localparam int LAT_W  = 16;
  localparam int LONG_W = 17;
  localparam int HUE_W  = 9;
  localparam int PX_W   = 12;
  localparam int PY_W   = 11;

  // Request codes carried in the operation field.
  localparam logic [OP_W-1:0] OP_START = 1'b0;
  localparam logic [OP_W-1:0] OP_TICK  = 1'b1;

  // Bit-serial multiply-divide unit operand widths.
  localparam int MD_A_W   = 17;
  localparam int MD_B_W   = 13;
  localparam int MD_D_W   = 17;
  localparam int MD_P_W   = MD_A_W + MD_B_W;
  localparam int MD_CNT_W = $clog2(MD_P_W);

  // Projection divisors: full longitude and latitude spans in 1/256 degree.
  localparam int COL_DIV = 92160;
  localparam int ROW_DIV = 46080;

  typedef struct packed {
    logic              start;
    logic [MD_A_W-1:0] a;
    logic [MD_B_W-1:0] b;
    logic [MD_D_W-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [MD_P_W-1:0] q;
  } md_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mlr_in_if.sv =====
// Request channel interface carrying one line start or tick request.
`default_nettype none

interface mlr_in_if;
  import mlr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [LAT_W-1:0]  src_lat;
  logic signed [LONG_W-1:0] src_long;
  logic signed [LAT_W-1:0]  dst_lat;
  logic signed [LONG_W-1:0] dst_long;
  logic [HUE_W-1:0]         hue;

  modport source (
    output valid, operation, src_lat, src_long, dst_lat, dst_long, hue,
    input  ready
  );

  modport sink (
    input  valid, operation, src_lat, src_long, dst_lat, dst_long, hue,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/mlr_out_if.sv =====
// Result channel interface carrying one pixel of a rasterized line.
`default_nettype none

interface mlr_out_if;
  import mlr_pkg::*;

  logic             valid;
  logic             ready;
  logic [PX_W-1:0]  pixel_x;
  logic [PY_W-1:0]  pixel_y;
  logic [HUE_W-1:0] pixel_hue;
  logic             last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_hue, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_hue, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/mlr_muldiv.sv =====
// Bit-serial unit computing floor(a * b / d): shift-add multiply, then restoring divide.
`default_nettype none

module mlr_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  mlr_pkg::md_req_t req,
  output mlr_pkg::md_rsp_t rsp
);
  import mlr_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} md_state_t;

  md_state_t           state_r, state_nxt;
  logic [MD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic [MD_A_W-1:0]   a_r, a_nxt;
  logic [MD_D_W-1:0]   d_r, d_nxt;
  logic [MD_A_W-1:0]   hi_r, hi_nxt;
  logic [MD_B_W-1:0]   lo_r, lo_nxt;
  logic [MD_D_W-1:0]   rem_r, rem_nxt;
  logic [MD_P_W-1:0]   quo_r, quo_nxt;

  logic [MD_A_W:0]     sum;
  logic [MD_P_W-1:0]   prod;
  logic [MD_D_W:0]     shifted;
  logic [MD_D_W:0]     trial;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    a_nxt     = a_r;
    d_nxt     = d_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;

    // One multiplier bit per cycle: add the multiplicand into the high half, shift right.
    sum     = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
    prod    = {sum, lo_r[MD_B_W-1:1]};
    // One quotient bit per cycle, most significant first.
    shifted = {rem_r, quo_r[MD_P_W-1]};
    trial   = shifted - {1'b0, d_r};

    case (state_r)
      M_IDLE: begin
        if (req.start) begin
          a_nxt     = req.a;
          d_nxt     = req.d;
          hi_nxt    = '0;
          lo_nxt    = req.b;
          cnt_nxt   = MD_CNT_W'(MD_B_W - 1);
          state_nxt = M_MUL;
        end
      end
      M_MUL: begin
        hi_nxt = prod[MD_P_W-1:MD_B_W];
        lo_nxt = prod[MD_B_W-1:0];
        if (cnt_r == '0) begin
          quo_nxt   = prod;
          rem_nxt   = '0;
          cnt_nxt   = MD_CNT_W'(MD_P_W - 1);
          state_nxt = M_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      M_DIV: begin
        if (!trial[MD_D_W]) begin
          rem_nxt = trial[MD_D_W-1:0];
          quo_nxt = {quo_r[MD_P_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[MD_D_W-1:0];
          quo_nxt = {quo_r[MD_P_W-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = M_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    d_r   <= d_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy = (state_r != M_IDLE);
  assign rsp.done = done_r;
  assign rsp.q    = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/map_line_rasterizer.sv =====
// Map line rasterizer top level: projects two map points and emits the line pixel by pixel.
// A tick request that draws runs its pixel through launch, the shared unit and the hold state
// into the output register; requests are taken one at a time, only while idle, and a tick
// with no line active is accepted and dropped. A start request runs four projections in turn
// on the shared bit-serial multiply-divide unit, then classifies the line's direction.
// Synchronous active-low reset returns the block to idle with no line and no pending pixel.
`default_nettype none

`include "map_line_rasterizer_assert.svh"

module map_line_rasterizer #(
  parameter int MAP_WIDTH  = 2048,
  parameter int MAP_HEIGHT = 1025
) (
  input  logic             clk,
  input  logic             rst_n,
  mlr_in_if.sink           in_ch,
  mlr_out_if.source        out_ch
);
  import mlr_pkg::*;

  // Offsets and clamped coordinates are worked in a small signed range.
  localparam int OFF_W   = 15;
  localparam int Q_W     = 14;
  localparam int COL_MAX = (MAP_WIDTH > 4095) ? 4095 : MAP_WIDTH;
  localparam int ROW_MAX = (MAP_HEIGHT - 1 > 2047) ? 2047 : MAP_HEIGHT - 1;
  localparam logic signed [OFF_W-1:0] HALF_W_S  = OFF_W'(MAP_WIDTH / 2);
  localparam logic signed [OFF_W-1:0] HALF_H_S  = OFF_W'(MAP_HEIGHT / 2);
  localparam logic signed [OFF_W-1:0] COL_MAX_S = OFF_W'(COL_MAX);
  localparam logic signed [OFF_W-1:0] ROW_MAX_S = OFF_W'(ROW_MAX);

  typedef enum logic [2:0] {S_IDLE, S_LAUNCH, S_PROJ, S_CLASS, S_PIX, S_HOLD} state_t;

  // Direction of the line: which coordinate is stepped and how the other one moves.
  // X forward with rows falling, X forward with rows rising, stepping rows with X falling
  // from the source, and stepping rows upward from the destination.
  typedef enum logic [1:0] {DIR_XF_YB, DIR_XF_YF, DIR_XB_YF, DIR_XB_YB} dir_t;

  // Control and line state.
  state_t            state_r, state_nxt;
  logic [1:0]        proj_idx_r, proj_idx_nxt;
  logic              pix_mode_r, pix_mode_nxt;
  logic              proj_neg_r, proj_neg_nxt;
  logic              drawing_r, drawing_nxt;
  dir_t              dir_r, dir_nxt;
  logic [PX_W-1:0]   start_col_r, start_col_nxt;
  logic [PY_W-1:0]   start_row_r, start_row_nxt;
  logic [PX_W-1:0]   end_col_r, end_col_nxt;
  logic [PY_W-1:0]   end_row_r, end_row_nxt;
  logic [PX_W-1:0]   step_cursor_r, step_cursor_nxt;
  logic [HUE_W-1:0]  line_hue_r, line_hue_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers.
  logic signed [LAT_W-1:0]  src_lat_r, src_lat_nxt;
  logic signed [LONG_W-1:0] src_long_r, src_long_nxt;
  logic signed [LAT_W-1:0]  dst_lat_r, dst_lat_nxt;
  logic signed [LONG_W-1:0] dst_long_r, dst_long_nxt;
  logic [PX_W-1:0]          res_x_r, res_x_nxt;
  logic [PY_W-1:0]          res_y_r, res_y_nxt;
  logic                     res_last_r, res_last_nxt;
  logic [PX_W-1:0]          out_x_r, out_x_nxt;
  logic [PY_W-1:0]          out_y_r, out_y_nxt;
  logic [HUE_W-1:0]         out_hue_r, out_hue_nxt;
  logic                     out_last_r, out_last_nxt;

  md_req_t md_req;
  md_rsp_t md_rsp;

  logic                     in_acc;
  logic                     out_free;
  logic signed [LONG_W-1:0] proj_val;
  logic [MD_A_W-1:0]        proj_mag;
  logic [PX_W-1:0]          y1e, y2e;
  logic [PX_W-1:0]          pa, pb, pd;
  logic [PX_W-1:0]          q_pix;
  logic [PX_W-1:0]          px, py, stop;
  logic                     pix_last;
  logic [Q_W-1:0]           q_proj;
  logic signed [OFF_W-1:0]  off;
  logic signed [OFF_W-1:0]  col_sum, row_sum;
  logic [PX_W-1:0]          col_clamp;
  logic [PY_W-1:0]          row_clamp;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // The shared unit computes floor(a * b / d) on magnitudes only.
  mlr_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  // Projection operand: longitudes on even passes, latitudes on odd passes.
  always_comb begin
    case (proj_idx_r)
      2'd0:    proj_val = src_long_r;
      2'd1:    proj_val = LONG_W'(src_lat_r);
      2'd2:    proj_val = dst_long_r;
      default: proj_val = LONG_W'(dst_lat_r);
    endcase
    proj_mag = proj_val[LONG_W-1] ? MD_A_W'(~proj_val + 1'b1) : MD_A_W'(proj_val);
  end

  // Pixel operands: the cursor offset, the span of the dependent coordinate and the
  // span of the stepped coordinate.
  assign y1e = PX_W'(start_row_r);
  assign y2e = PX_W'(end_row_r);

  always_comb begin
    case (dir_r)
      DIR_XF_YB: begin
        pa = step_cursor_r - start_col_r;
        pb = y1e - y2e;
        pd = end_col_r - start_col_r;
      end
      DIR_XF_YF: begin
        pa = step_cursor_r - start_col_r;
        pb = y2e - y1e;
        pd = end_col_r - start_col_r;
      end
      DIR_XB_YF: begin
        pa = step_cursor_r - y1e;
        pb = start_col_r - end_col_r;
        pd = y2e - y1e;
      end
      default: begin
        pa = step_cursor_r - y2e;
        pb = start_col_r - end_col_r;
        pd = y1e - y2e;
      end
    endcase
  end

  always_comb begin
    md_req.start = (state_r == S_LAUNCH);
    if (pix_mode_r) begin
      md_req.a = MD_A_W'(pa);
      md_req.b = MD_B_W'(pb);
      md_req.d = MD_D_W'(pd);
    end else begin
      md_req.a = proj_mag;
      md_req.b = proj_idx_r[0] ? MD_B_W'(MAP_HEIGHT) : MD_B_W'(MAP_WIDTH);
      md_req.d = proj_idx_r[0] ? MD_D_W'(ROW_DIV) : MD_D_W'(COL_DIV);
    end
  end

  // Projection result: restore the sign of the truncated offset, add it to the map
  // center (subtract for rows, since north is up) and saturate to the map.
  always_comb begin
    q_proj  = md_rsp.q[Q_W-1:0];
    off     = proj_neg_r ? -$signed(OFF_W'(q_proj)) : $signed(OFF_W'(q_proj));
    col_sum = HALF_W_S + off;
    row_sum = HALF_H_S - off;
    if (col_sum < 0) begin
      col_clamp = '0;
    end else if (col_sum > COL_MAX_S) begin
      col_clamp = PX_W'(COL_MAX);
    end else begin
      col_clamp = col_sum[PX_W-1:0];
    end
    if (row_sum < 0) begin
      row_clamp = '0;
    end else if (row_sum > ROW_MAX_S) begin
      row_clamp = PY_W'(ROW_MAX);
    end else begin
      row_clamp = row_sum[PY_W-1:0];
    end
  end

  // Pixel result: the quotient moves the dependent coordinate away from its base.
  always_comb begin
    q_pix = md_rsp.q[PX_W-1:0];
    case (dir_r)
      DIR_XF_YB: begin
        px   = step_cursor_r;
        py   = y1e - q_pix;
        stop = end_col_r;
      end
      DIR_XF_YF: begin
        px   = step_cursor_r;
        py   = y1e + q_pix;
        stop = end_col_r;
      end
      DIR_XB_YF: begin
        px   = start_col_r - q_pix;
        py   = step_cursor_r;
        stop = y2e;
      end
      default: begin
        px   = end_col_r + q_pix;
        py   = step_cursor_r;
        stop = y1e;
      end
    endcase
    pix_last = (step_cursor_r >= stop);
  end

  always_comb begin
    state_nxt       = state_r;
    proj_idx_nxt    = proj_idx_r;
    pix_mode_nxt    = pix_mode_r;
    proj_neg_nxt    = proj_neg_r;
    drawing_nxt     = drawing_r;
    dir_nxt         = dir_r;
    start_col_nxt   = start_col_r;
    start_row_nxt   = start_row_r;
    end_col_nxt     = end_col_r;
    end_row_nxt     = end_row_r;
    step_cursor_nxt = step_cursor_r;
    line_hue_nxt    = line_hue_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;

    src_lat_nxt  = src_lat_r;
    src_long_nxt = src_long_r;
    dst_lat_nxt  = dst_lat_r;
    dst_long_nxt = dst_long_r;
    res_x_nxt    = res_x_r;
    res_y_nxt    = res_y_r;
    res_last_nxt = res_last_r;
    out_x_nxt    = out_x_r;
    out_y_nxt    = out_y_r;
    out_hue_nxt  = out_hue_r;
    out_last_nxt = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.operation == OP_START) begin
            // A start abandons any line in progress and loads the new end points.
            src_lat_nxt  = in_ch.src_lat;
            src_long_nxt = in_ch.src_long;
            dst_lat_nxt  = in_ch.dst_lat;
            dst_long_nxt = in_ch.dst_long;
            line_hue_nxt = in_ch.hue;
            drawing_nxt  = 1'b0;
            proj_idx_nxt = 2'd0;
            pix_mode_nxt = 1'b0;
            state_nxt    = S_LAUNCH;
          end else if (drawing_r) begin
            pix_mode_nxt = 1'b1;
            state_nxt    = S_LAUNCH;
          end
        end
      end
      S_LAUNCH: begin
        proj_neg_nxt = proj_val[LONG_W-1];
        state_nxt    = pix_mode_r ? S_PIX : S_PROJ;
      end
      S_PROJ: begin
        if (md_rsp.done) begin
          case (proj_idx_r)
            2'd0:    start_col_nxt = col_clamp;
            2'd1:    start_row_nxt = row_clamp;
            2'd2:    end_col_nxt   = col_clamp;
            default: end_row_nxt   = row_clamp;
          endcase
          if (proj_idx_r == 2'd3) begin
            state_nxt = S_CLASS;
          end else begin
            proj_idx_nxt = proj_idx_r + 1'b1;
            state_nxt    = S_LAUNCH;
          end
        end
      end
      S_CLASS: begin
        // A line with equal columns or equal rows at its ends draws nothing.
        drawing_nxt = 1'b1;
        if (start_col_r < end_col_r && start_row_r > end_row_r) begin
          dir_nxt         = DIR_XF_YB;
          step_cursor_nxt = start_col_r;
        end else if (start_col_r < end_col_r && start_row_r < end_row_r) begin
          dir_nxt         = DIR_XF_YF;
          step_cursor_nxt = start_col_r;
        end else if (start_col_r > end_col_r && start_row_r < end_row_r) begin
          dir_nxt         = DIR_XB_YF;
          step_cursor_nxt = y1e;
        end else if (start_col_r > end_col_r && start_row_r > end_row_r) begin
          dir_nxt         = DIR_XB_YB;
          step_cursor_nxt = y2e;
        end else begin
          dir_nxt         = DIR_XF_YB;
          step_cursor_nxt = '0;
          drawing_nxt     = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      S_PIX: begin
        if (md_rsp.done) begin
          res_x_nxt    = px;
          res_y_nxt    = py[PY_W-1:0];
          res_last_nxt = pix_last;
          if (pix_last) begin
            drawing_nxt = 1'b0;
          end else begin
            step_cursor_nxt = step_cursor_r + 1'b1;
          end
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        // Wait for the output register to free up before taking the next request.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = res_x_r;
          out_y_nxt     = res_y_r;
          out_hue_nxt   = line_hue_r;
          out_last_nxt  = res_last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      proj_idx_r    <= 2'd0;
      pix_mode_r    <= 1'b0;
      proj_neg_r    <= 1'b0;
      drawing_r     <= 1'b0;
      dir_r         <= DIR_XF_YB;
      start_col_r   <= '0;
      start_row_r   <= '0;
      end_col_r     <= '0;
      end_row_r     <= '0;
      step_cursor_r <= '0;
      line_hue_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      proj_idx_r    <= proj_idx_nxt;
      pix_mode_r    <= pix_mode_nxt;
      proj_neg_r    <= proj_neg_nxt;
      drawing_r     <= drawing_nxt;
      dir_r         <= dir_nxt;
      start_col_r   <= start_col_nxt;
      start_row_r   <= start_row_nxt;
      end_col_r     <= end_col_nxt;
      end_row_r     <= end_row_nxt;
      step_cursor_r <= step_cursor_nxt;
      line_hue_r    <= line_hue_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_lat_r  <= src_lat_nxt;
    src_long_r <= src_long_nxt;
    dst_lat_r  <= dst_lat_nxt;
    dst_long_r <= dst_long_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    res_last_r <= res_last_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_hue_r  <= out_hue_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_x   = out_x_r;
  assign out_ch.pixel_y   = out_y_r;
  assign out_ch.pixel_hue = out_hue_r;
  assign out_ch.last      = out_last_r;

  // The shared unit only runs while a projection or a pixel is waiting on it.
  `MLR_ASSERT_NOW(a_md_busy_owned, md_rsp.busy, (state_r == S_PROJ || state_r == S_PIX))
  // Launching an operation always starts the unit.
  `MLR_ASSERT_NEXT(a_md_launch, state_r == S_LAUNCH, md_rsp.busy)
  // An active line never has equal end columns or equal end rows.
  `MLR_ASSERT_NOW(a_draw_nondegen, drawing_r,
                  (start_col_r != end_col_r) && (start_row_r != end_row_r))
  // While stepping columns the cursor never passes the end column.
  `MLR_ASSERT_NOW(a_cursor_bound, drawing_r && (dir_r == DIR_XF_YB || dir_r == DIR_XF_YF),
                  step_cursor_r <= end_col_r)

endmodule

`default_nettype wire
